// ===== sv/blpl_pkg.sv =====
// Shared types and constants for the bounded positional list unit.
// No dependencies; every other file imports this package.
package blpl_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W = 5;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_END   = 3'd1;
   localparam logic [2:0] OP_INS_POS   = 3'd2;
   localparam logic [2:0] OP_DEL_FRONT = 3'd3;
   localparam logic [2:0] OP_DEL_END   = 3'd4;
   localparam logic [2:0] OP_DEL_POS   = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_OOB   = 2'd3;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic [1:0]         status;
      logic [4:0]         entry_count;
   } rsp_type;

   // Broadcast to every cell: open a gap or close one at pos.
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [IDX_W-1:0] pos;
   } ctl_type;

endpackage

// ===== sv/blpl_cell.sv =====
// One storage cell of the list row: holds one entry and trades it with its neighbors.
// Depends on blpl_pkg.
module blpl_cell import blpl_pkg::*; (
   input  logic               clock,
   input  ctl_type            cmd,
   input  logic [IDX_W-1:0]   cell_idx,
   input  logic signed [31:0] new_val,
   input  logic signed [31:0] left_val,
   input  logic signed [31:0] right_val,
   output logic signed [31:0] val,
   output logic signed [31:0] hit_val
);

   logic signed [31:0] val_ff;
   logic signed [31:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (cmd.ins) begin
         if (cell_idx == cmd.pos) begin
            val_in = new_val;
         end else if (cell_idx > cmd.pos) begin
            val_in = left_val;
         end
      end else if (cmd.del) begin
         // close the gap: everything at or past pos advances toward the front
         if (cell_idx >= cmd.pos) begin
            val_in = right_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val     = val_ff;
   assign hit_val = (cell_idx == cmd.pos) ? val_ff : 32'sd0;

endmodule

// ===== sv/blpl_ctrl.sv =====
// Command decode and entry count for the list: checks full, empty and bounds.
// Depends on blpl_pkg.
module blpl_ctrl import blpl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  req_type          req,
   output ctl_type          cmd,
   output logic [1:0]       status,
   output logic [CNT_W-1:0] count_next
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             full;
   logic             empty;
   logic             do_ins;
   logic             do_del;
   logic [IDX_W-1:0] pos_sel;

   assign pos_ext = CMP_W'(req.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);

   always_comb begin
      status  = ST_OK;
      do_ins  = 1'b0;
      do_del  = 1'b0;
      pos_sel = '0;
      case (req.opcode)
         OP_INS_FRONT: begin
            if (full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_INS_END: begin
            pos_sel = IDX_W'(count_ff);
            if (full) status = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_INS_POS: begin
            pos_sel = IDX_W'(req.position);
            if (full) status = ST_FULL;
            else if (pos_ext > cnt_ext) status = ST_OOB;
            else do_ins = 1'b1;
         end
         OP_DEL_FRONT: begin
            if (empty) status = ST_EMPTY;
            else do_del = 1'b1;
         end
         OP_DEL_END: begin
            pos_sel = IDX_W'(count_ff - CNT_W'(1));
            if (empty) status = ST_EMPTY;
            else do_del = 1'b1;
         end
         OP_DEL_POS: begin
            pos_sel = IDX_W'(req.position);
            if (empty) status = (req.position == '0) ? ST_EMPTY : ST_OOB;
            else if (pos_ext >= cnt_ext) status = ST_OOB;
            else do_del = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_next = count_ff;
      if (do_ins) count_next = count_ff + CNT_W'(1);
      else if (do_del) count_next = count_ff - CNT_W'(1);
   end

   assign count_in = accept ? count_next : count_ff;
   assign cmd.ins  = accept & do_ins;
   assign cmd.del  = accept & do_del;
   assign cmd.pos  = pos_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/bounded_positional_list_unit.sv =====
// Bounded positional list unit: an ordered list of up to DEPTH signed 32-bit entries held in
// a row of cells, entry 0 at the front. Each request inserts at the front, the end or a
// position, or deletes from the front, the end or a position, and yields one response with
// status, removed value and new count. All cells shift or hold in parallel in the cycle a request is
// accepted, and its response appears in the output register on the next cycle. A new request is
// taken every cycle while the response register is empty or being drained. Depends on blpl_pkg,
// blpl_cell and blpl_ctrl.
module bounded_positional_list_unit import blpl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic               accept;
   ctl_type            cmd;
   logic [1:0]         status;
   logic [CNT_W-1:0]   count_next;
   logic signed [31:0] cell_val [DEPTH];
   logic signed [31:0] hit_val  [DEPTH];
   logic signed [31:0] hit_or;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   blpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_payload),
      .cmd        (cmd),
      .status     (status),
      .count_next (count_next)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_val;
      logic signed [31:0] right_val;
      if (i == 0) begin : g_first
         assign left_val = req_payload.value;
      end else begin : g_mid_l
         assign left_val = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_val = cell_val[i];
      end else begin : g_mid_r
         assign right_val = cell_val[i+1];
      end
      blpl_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .cell_idx  (IDX_W'(i)),
         .new_val   (req_payload.value),
         .left_val  (left_val),
         .right_val (right_val),
         .val       (cell_val[i]),
         .hit_val   (hit_val[i])
      );
   end

   always_comb begin
      hit_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_or = hit_or | hit_val[i];
      end
   end

   always_comb begin
      rsp_in.removed_value = cmd.del ? hit_or : 32'sd0;
      rsp_in.status        = status;
      rsp_in.entry_count   = 5'(count_next);
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/blpl_checker.sv =====
// Port-level checks for the bounded positional list unit, bound to the top level.
// Depends on blpl_pkg and bounded_positional_list_unit.
module blpl_checker import blpl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // response register empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.removed_value == 32'sd0)
      else $error("failed request returned a value");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FULL |-> rsp_payload.entry_count == 5'(DEPTH))
      else $error("full status with short count");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_EMPTY |-> rsp_payload.entry_count == 5'd0)
      else $error("empty status with entries held");

endmodule

bind bounded_positional_list_unit blpl_checker u_blpl_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
